FILE: rtl/psdt_pkg.sv
// shared types and constants of the distinct-port tracker
// no dependencies; imported by every module of the block
package psdt_pkg;

	localparam int TABLE_ENTRIES_DEF = 256;
	localparam int HISTORY_DEPTH_DEF = 32;

	localparam logic [15:0] WINDOW_RESET    = 16'd60;
	localparam logic [15:0] THRESHOLD_RESET = 16'd20;

	localparam logic [7:0] REG_WINDOW    = 8'd0;
	localparam logic [7:0] REG_THRESHOLD = 8'd1;

	localparam logic [1:0] V_NO_ENTRY        = 2'd0;
	localparam logic [1:0] V_COUNTING        = 2'd1;
	localparam logic [1:0] V_NEWLY_BLOCKED   = 2'd2;
	localparam logic [1:0] V_ALREADY_BLOCKED = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SRD,
		ST_SCMP,
		ST_PRD,
		ST_PCMP,
		ST_PEND,
		ST_FREE,
		ST_CHK,
		ST_RRD,
		ST_RCMP,
		ST_UPD
	} state_t;

	typedef struct packed {
		logic load;
		logic idx_clr;
		logic idx_inc;
		logic slot_rd;
		logic take_hit;
		logic prune_clr;
		logic alloc;
		logic restart;
		logic ring_rd;
		logic ring_cmp;
		logic update;
		logic noentry;
	} dp_cmd_t;

	typedef struct packed {
		logic hit;
		logic vld;
		logic exp;
		logic slot_last;
		logic ring_last;
		logic full;
	} dp_sts_t;

endpackage

FILE: rtl/psdt_dp.sv
// datapath: slot table, ring memory, valid bits, occupancy and result registers
// depends on psdt_pkg; driven by psdt_ctrl
module psdt_dp import psdt_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] source_address,
	input  logic [15:0] dest_port,
	input  logic [31:0] now_seconds,
	input  logic [15:0] window_seconds,
	input  logic [15:0] block_threshold,
	input  dp_cmd_t     cmd,
	output dp_sts_t     sts,
	output logic        done,
	output logic [1:0]  verdict,
	output logic [15:0] distinct_count
);

	localparam int SW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CW = (SW > HW) ? SW : HW;
	localparam int RING_WORDS = TABLE_ENTRIES << HW;

	typedef struct packed {
		logic [31:0]   src;
		logic [31:0]   win_start;
		logic [HW-1:0] ptr;
		logic          full;
		logic [15:0]   cnt;
		logic          blk;
	} slot_rec_t;

	slot_rec_t slot_mem [TABLE_ENTRIES];
	logic [15:0] ring_mem [RING_WORDS];

	logic [31:0]        src_q;
	logic [15:0]        port_q;
	logic [31:0]        now_q;
	logic [CW-1:0]      idx_q;
	logic [SW-1:0]      slot_q;
	slot_rec_t          rec_q;
	slot_rec_t          rd_q;
	logic [15:0]        ring_rd_q;
	logic               seen_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [SW:0]        occ_q;
	logic               done_q;
	logic [1:0]         verdict_q;
	logic [15:0]        count_q;

	logic [SW-1:0] sidx;
	logic [HW-1:0] ridx;
	logic [31:0]   elapsed_rd;
	logic [31:0]   elapsed_rec;
	logic          exp_rec;
	logic          upd_seen;
	logic [15:0]   new_dist;
	logic          over;
	logic [1:0]    upd_verdict;
	slot_rec_t     rec_new;

	assign sidx = idx_q[SW-1:0];
	assign ridx = idx_q[HW-1:0];

	assign elapsed_rd  = now_q - rd_q.win_start;
	assign elapsed_rec = now_q - rec_q.win_start;
	assign exp_rec     = elapsed_rec > {16'd0, window_seconds};

	always_comb begin
		sts.hit       = valid_q[sidx] && (rd_q.src == src_q);
		sts.vld       = valid_q[sidx];
		sts.exp       = elapsed_rd > {16'd0, window_seconds};
		sts.slot_last = idx_q == CW'(TABLE_ENTRIES - 1);
		sts.ring_last = idx_q == CW'(HISTORY_DEPTH - 1);
		sts.full      = occ_q >= (SW + 1)'(TABLE_ENTRIES);
	end

	// while the ring is not yet full, port zero counts as already seen
	always_comb begin
		upd_seen = seen_q || ((port_q == 16'd0) && !rec_q.full);
		new_dist = (!upd_seen && (rec_q.cnt != 16'hFFFF)) ? rec_q.cnt + 16'd1 : rec_q.cnt;
		over     = new_dist > block_threshold;
		if (!over) begin
			upd_verdict = V_COUNTING;
		end else if (rec_q.blk) begin
			upd_verdict = V_ALREADY_BLOCKED;
		end else begin
			upd_verdict = V_NEWLY_BLOCKED;
		end
		rec_new      = rec_q;
		rec_new.cnt  = new_dist;
		rec_new.blk  = rec_q.blk | over;
		rec_new.ptr  = (rec_q.ptr == HW'(HISTORY_DEPTH - 1)) ? '0 : rec_q.ptr + HW'(1);
		rec_new.full = rec_q.full | (rec_q.ptr == HW'(HISTORY_DEPTH - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.update | cmd.noentry;
			if (cmd.prune_clr) begin
				valid_q[sidx] <= 1'b0;
				occ_q         <= occ_q - (SW + 1)'(1);
			end else if (cmd.alloc) begin
				valid_q[sidx] <= 1'b1;
				occ_q         <= occ_q + (SW + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			src_q  <= source_address;
			port_q <= dest_port;
			now_q  <= now_seconds;
			seen_q <= 1'b0;
		end
		if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + CW'(1);
		end
		if (cmd.take_hit) begin
			rec_q  <= rd_q;
			slot_q <= sidx;
		end else if (cmd.alloc) begin
			rec_q.src       <= src_q;
			rec_q.win_start <= now_q;
			rec_q.ptr       <= '0;
			rec_q.full      <= 1'b0;
			rec_q.cnt       <= '0;
			rec_q.blk       <= 1'b0;
			slot_q          <= sidx;
		end else if (cmd.restart && exp_rec) begin
			rec_q.win_start <= now_q;
			rec_q.ptr       <= '0;
			rec_q.full      <= 1'b0;
			rec_q.cnt       <= '0;
			rec_q.blk       <= 1'b0;
		end
		if (cmd.ring_cmp && (ring_rd_q == port_q) && (rec_q.full || (ridx < rec_q.ptr))) begin
			seen_q <= 1'b1;
		end
		if (cmd.update) begin
			verdict_q <= upd_verdict;
			count_q   <= new_dist;
		end else if (cmd.noentry) begin
			verdict_q <= V_NO_ENTRY;
			count_q   <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.slot_rd) begin
			rd_q <= slot_mem[sidx];
		end
		if (cmd.update) begin
			slot_mem[slot_q] <= rec_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ring_rd) begin
			ring_rd_q <= ring_mem[{slot_q, ridx}];
		end
		if (cmd.update) begin
			ring_mem[{slot_q, rec_q.ptr}] <= port_q;
		end
	end

	assign done           = done_q;
	assign verdict        = verdict_q;
	assign distinct_count = count_q;

	a_occ_max: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= (SW + 1)'(TABLE_ENTRIES))
		else $error("occupancy above table size");
	a_occ_match: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q == (SW + 1)'($countones(valid_q)))
		else $error("occupancy out of step with valid bits");
	a_alloc_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc |-> !valid_q[sidx])
		else $error("allocation into an occupied slot");
	a_noentry_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.noentry |=> (done && distinct_count == 16'd0))
		else $error("no_entry result with nonzero count");

endmodule

FILE: rtl/psdt_ctrl.sv
// controller: sequences slot search, pruning, allocation and ring compare
// depends on psdt_pkg; commands psdt_dp
module psdt_ctrl import psdt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  dp_sts_t sts,
	output dp_cmd_t cmd,
	output logic    busy
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load    = 1'b1;
					cmd.idx_clr = 1'b1;
					state_nxt   = ST_SRD;
				end
			end
			ST_SRD: begin
				cmd.slot_rd = 1'b1;
				state_nxt   = ST_SCMP;
			end
			ST_SCMP: begin
				if (sts.hit) begin
					cmd.take_hit = 1'b1;
					state_nxt    = ST_CHK;
				end else if (sts.slot_last) begin
					cmd.idx_clr = 1'b1;
					state_nxt   = sts.full ? ST_PRD : ST_FREE;
				end else begin
					cmd.idx_inc = 1'b1;
					state_nxt   = ST_SRD;
				end
			end
			ST_PRD: begin
				cmd.slot_rd = 1'b1;
				state_nxt   = ST_PCMP;
			end
			ST_PCMP: begin
				cmd.prune_clr = sts.vld & sts.exp;
				if (sts.slot_last) begin
					cmd.idx_clr = 1'b1;
					state_nxt   = ST_PEND;
				end else begin
					cmd.idx_inc = 1'b1;
					state_nxt   = ST_PRD;
				end
			end
			ST_PEND: begin
				if (sts.full) begin
					cmd.noentry = 1'b1;
					state_nxt   = ST_IDLE;
				end else begin
					state_nxt = ST_FREE;
				end
			end
			ST_FREE: begin
				if (!sts.vld) begin
					cmd.alloc   = 1'b1;
					cmd.idx_clr = 1'b1;
					state_nxt   = ST_RRD;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			ST_CHK: begin
				cmd.restart = 1'b1;
				cmd.idx_clr = 1'b1;
				state_nxt   = ST_RRD;
			end
			ST_RRD: begin
				cmd.ring_rd = 1'b1;
				state_nxt   = ST_RCMP;
			end
			ST_RCMP: begin
				cmd.ring_cmp = 1'b1;
				if (sts.ring_last) begin
					state_nxt = ST_UPD;
				end else begin
					cmd.idx_inc = 1'b1;
					state_nxt   = ST_RRD;
				end
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				state_nxt  = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	assign busy = state_q != ST_IDLE;

endmodule

FILE: rtl/port_scan_distinct_port_tracker.sv
// top level of the distinct-port tracker: config registers, controller, datapath
// depends on psdt_pkg, psdt_ctrl and psdt_dp
//
// channel   direction  handshake            beat
// item      in         start & !busy        source_address, dest_port, now_seconds
// result    out        done (one cycle)     verdict, distinct_count
// config    in         wr_en                wr_index, wr_data
//
// a hit at slot k keeps busy high while the slots up to k are scanned and the whole ring is compared
// a miss scans all slots, walks to the first free slot j, then compares
// the ring before the update
// a full table adds a prune pass over all slots; no_entry ends after
// that pass if the table is still full
// the walks are set by the single read port of the slot table and of the port ring
// reset clears the valid bits and occupancy at once, so no clearing pass is needed
// the result strobe is done, raised in the same cycle that busy drops; the receiver cannot stall it
module port_scan_distinct_port_tracker import psdt_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] source_address,
	input  logic [15:0] dest_port,
	input  logic [31:0] now_seconds,
	output logic        done,
	output logic [1:0]  verdict,
	output logic [15:0] distinct_count,
	input  logic        wr_en,
	input  logic [7:0]  wr_index,
	input  logic [15:0] wr_data
);

	logic [15:0] window_q;
	logic [15:0] threshold_q;
	dp_cmd_t     cmd;
	dp_sts_t     sts;

	// register writes; unknown indexes drop silently
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= WINDOW_RESET;
			threshold_q <= THRESHOLD_RESET;
		end else if (wr_en) begin
			if (wr_index == REG_WINDOW) begin
				window_q <= wr_data;
			end else if (wr_index == REG_THRESHOLD) begin
				threshold_q <= wr_data;
			end
		end
	end

	// sequencer: search, prune, allocate, ring compare, update
	psdt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// slot table, port ring and result registers
	psdt_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.source_address  (source_address),
		.dest_port       (dest_port),
		.now_seconds     (now_seconds),
		.window_seconds  (window_q),
		.block_threshold (threshold_q),
		.cmd             (cmd),
		.sts             (sts),
		.done            (done),
		.verdict         (verdict),
		.distinct_count  (distinct_count)
	);

endmodule
